>>> rtl/core/ss3g_pkg.sv
`default_nettype none

package ss3g_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int DATA_W       = 32;
   localparam int POS_W        = 7;
   localparam int GAP_NUM      = 17;
   localparam int GIDX_W       = 5;

   typedef enum logic [1:0] {
      RD_I,
      RD_JG,
      RD_K
   } rd_sel_type;

   typedef struct packed {
      logic       load_wr;
      logic       sort_start;
      logic       gap_dec;
      logic       i_init;
      logic       i_inc;
      logic       held_ld;
      logic       shift_wr;
      logic       held_wr;
      logic       out_init;
      logic       out_ld;
      logic       count_clr;
      rd_sel_type rd_sel;
   } cmd_type;

   typedef struct packed {
      logic set_ends;
      logic gap_gt_n;
      logic gap_last;
      logic i_done;
      logic j_ge_gap;
      logic greater;
      logic k_last;
      logic rsp_free;
   } status_type;

   // 3-smooth gaps, smallest first
   function automatic logic [POS_W-1:0] gap_at(input logic [GIDX_W-1:0] idx);
      logic [POS_W-1:0] g;
      unique case (idx)
         5'd0:    g = 7'd1;
         5'd1:    g = 7'd2;
         5'd2:    g = 7'd3;
         5'd3:    g = 7'd4;
         5'd4:    g = 7'd6;
         5'd5:    g = 7'd8;
         5'd6:    g = 7'd9;
         5'd7:    g = 7'd12;
         5'd8:    g = 7'd16;
         5'd9:    g = 7'd18;
         5'd10:   g = 7'd24;
         5'd11:   g = 7'd27;
         5'd12:   g = 7'd32;
         5'd13:   g = 7'd36;
         5'd14:   g = 7'd48;
         5'd15:   g = 7'd54;
         5'd16:   g = 7'd64;
         default: g = 7'd1;
      endcase
      return g;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/ss3g_ram.sv
`default_nettype none

module ss3g_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/core/ss3g_ctrl.sv
`default_nettype none

module ss3g_ctrl
   import ss3g_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_SORT_INIT,
      ST_GAP_FIND,
      ST_PASS_RD,
      ST_PASS_HELD,
      ST_J_CHK,
      ST_J_CMP,
      ST_OUT_RD,
      ST_OUT_LD
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.rd_sel = RD_I;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               cmd.load_wr = 1'b1;
               if (status.set_ends) begin
                  state_in = ST_SORT_INIT;
               end
            end
         end
         ST_SORT_INIT: begin
            cmd.sort_start = 1'b1;
            state_in       = ST_GAP_FIND;
         end
         ST_GAP_FIND: begin
            if (status.gap_gt_n) begin
               cmd.gap_dec = 1'b1;
            end else begin
               cmd.i_init = 1'b1;
               state_in   = ST_PASS_RD;
            end
         end
         ST_PASS_RD: begin
            if (status.i_done) begin
               if (status.gap_last) begin
                  cmd.out_init = 1'b1;
                  state_in     = ST_OUT_RD;
               end else begin
                  cmd.gap_dec = 1'b1;
                  state_in    = ST_GAP_FIND;
               end
            end else begin
               cmd.rd_sel = RD_I;
               state_in   = ST_PASS_HELD;
            end
         end
         ST_PASS_HELD: begin
            cmd.held_ld = 1'b1;
            state_in    = ST_J_CHK;
         end
         ST_J_CHK: begin
            if (status.j_ge_gap) begin
               cmd.rd_sel = RD_JG;
               state_in   = ST_J_CMP;
            end else begin
               cmd.held_wr = 1'b1;
               cmd.i_inc   = 1'b1;
               state_in    = ST_PASS_RD;
            end
         end
         ST_J_CMP: begin
            if (status.greater) begin
               cmd.shift_wr = 1'b1;
               state_in     = ST_J_CHK;
            end else begin
               cmd.held_wr = 1'b1;
               cmd.i_inc   = 1'b1;
               state_in    = ST_PASS_RD;
            end
         end
         ST_OUT_RD: begin
            cmd.rd_sel = RD_K;
            if (status.rsp_free) begin
               state_in = ST_OUT_LD;
            end
         end
         ST_OUT_LD: begin
            cmd.out_ld = 1'b1;
            if (status.k_last) begin
               cmd.count_clr = 1'b1;
               state_in      = ST_LOAD;
            end else begin
               state_in = ST_OUT_RD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         req_ready_ff <= 1'b1;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= (state_in == ST_LOAD);
      end
   end

   assign req_ready = req_ready_ff;

endmodule

`default_nettype wire

>>> rtl/core/ss3g_dpath.sv
`default_nettype none

module ss3g_dpath
   import ss3g_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic signed [DATA_W-1:0] req_value,
   input  wire logic                     req_last,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic signed [DATA_W-1:0]      rsp_sorted_value,
   output logic                          rsp_end_of_set,
   input  wire cmd_type                  cmd,
   output status_type                    status
);

   localparam int IDX_W = $clog2(CAPACITY);

   logic [POS_W-1:0]         count_ff, count_in;
   logic [GIDX_W-1:0]        gidx_ff, gidx_in;
   logic [POS_W-1:0]         i_ff, i_in;
   logic [POS_W-1:0]         j_ff, j_in;
   logic [POS_W-1:0]         k_ff, k_in;
   logic signed [DATA_W-1:0] held_ff, held_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic                     rsp_end_ff, rsp_end_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic [POS_W-1:0]         gap;
   logic [POS_W-1:0]         j_back;
   logic signed [DATA_W-1:0] rd_data;
   logic [IDX_W-1:0]         rd_addr;
   logic [IDX_W-1:0]         wr_addr;
   logic [DATA_W-1:0]        wr_data;
   logic                     wr_en;

   assign gap    = gap_at(gidx_ff);
   assign j_back = j_ff - gap;

   always_comb begin
      case (cmd.rd_sel)
         RD_I:    rd_addr = i_ff[IDX_W-1:0];
         RD_JG:   rd_addr = j_back[IDX_W-1:0];
         RD_K:    rd_addr = k_ff[IDX_W-1:0];
         default: rd_addr = '0;
      endcase
   end

   assign wr_en   = cmd.load_wr | cmd.shift_wr | cmd.held_wr;
   assign wr_addr = cmd.load_wr ? count_ff[IDX_W-1:0] : j_ff[IDX_W-1:0];
   assign wr_data = cmd.load_wr  ? req_value :
                    cmd.shift_wr ? rd_data   : held_ff;

   ss3g_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      status.set_ends = req_last | ((count_ff + 7'd1) == POS_W'(CAPACITY));
      status.gap_gt_n = gap > count_ff;
      status.gap_last = (gidx_ff == '0);
      status.i_done   = i_ff >= count_ff;
      status.j_ge_gap = j_ff >= gap;
      status.greater  = rd_data > held_ff;
      status.k_last   = (k_ff == (count_ff - 7'd1));
      status.rsp_free = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      count_in     = count_ff;
      gidx_in      = gidx_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      held_in      = held_ff;
      rsp_value_in = rsp_value_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.load_wr) begin
         count_in = count_ff + 7'd1;
      end
      if (cmd.count_clr) begin
         count_in = '0;
      end
      if (cmd.sort_start) begin
         gidx_in = GIDX_W'(GAP_NUM - 1);
      end
      if (cmd.gap_dec) begin
         gidx_in = gidx_ff - 5'd1;
      end
      if (cmd.i_init) begin
         i_in = gap;
      end
      if (cmd.i_inc) begin
         i_in = i_ff + 7'd1;
      end
      if (cmd.held_ld) begin
         held_in = rd_data;
         j_in    = i_ff;
      end
      if (cmd.shift_wr) begin
         j_in = j_back;
      end
      if (cmd.out_init) begin
         k_in = '0;
      end
      if (cmd.out_ld) begin
         rsp_value_in = rd_data;
         rsp_end_in   = status.k_last;
         rsp_valid_in = 1'b1;
         k_in         = k_ff + 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         gidx_ff      <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         gidx_ff      <= gidx_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      held_ff      <= held_in;
      rsp_value_ff <= rsp_value_in;
      rsp_end_ff   <= rsp_end_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_end_of_set   = rsp_end_ff;

endmodule

`default_nettype wire

>>> rtl/core/shell_sort_smooth3_gaps_core.sv
// Shell sort of signed 32-bit values with 3-smooth gaps (1, 2, 3, 4, 6, 8, 9, ...).
// Request channel (req_valid/req_ready): one value per request; req_last ends
// the set, and the request that fills the store (CAPACITY values) ends it too.
// Each request while loading stores one value; req_ready is high only while loading.
// Once a set ends the block sorts it in place in a single-port-read store:
// each gap pass reads every element past the gap into a held register, shifts
// larger elements up its gap chain one gap step at a time, then writes the held
// value into the freed slot; gaps above the set size are skipped. The sort time
// is set by the store's one registered read port.
// Response channel (rsp_valid/rsp_ready): the sorted values leave in ascending
// order from an output register, with rsp_end_of_set on the last one; the next
// value is loaded only once the register is empty or being taken. A stalled
// receiver simply holds the output register and the readout waits; the next set
// can start loading while the previous set's last sorted value is still not taken.
// Reset (synchronous, active high) empties the store count, drops rsp_valid
// and returns to loading; store contents are not cleared.
`default_nettype none

module shell_sort_smooth3_gaps_core
   import ss3g_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic signed [DATA_W-1:0] req_value,
   input  wire logic                     req_last,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic signed [DATA_W-1:0]      rsp_sorted_value,
   output logic                          rsp_end_of_set
);

   cmd_type    cmd;
   status_type status;

   ss3g_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ss3g_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_value        (req_value),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_end_of_set   (rsp_end_of_set),
      .cmd              (cmd),
      .status           (status)
   );

   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_wr, cmd.shift_wr, cmd.held_wr}))
      else $error("store written by more than one source");

   a_no_sort_while_loading: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (!cmd.shift_wr && !cmd.held_wr && !cmd.out_ld))
      else $error("sort or readout active while accepting requests");

   a_out_reg_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_ld |-> (!rsp_valid || rsp_ready))
      else $error("output register overwritten before it was taken");

endmodule

`default_nettype wire
